FILE: rtl/core/round_robin_thread_scheduler_defines.svh
// ----------------------------------------------------------------------------
// Round-robin thread scheduler assertion macros
// Shared property forms for the scheduler checkers.
// ----------------------------------------------------------------------------
`ifndef ROUND_ROBIN_THREAD_SCHEDULER_DEFINES_SVH
`define ROUND_ROBIN_THREAD_SCHEDULER_DEFINES_SVH

// same-cycle implication
`define RRTS_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rrts checker: property failed");

// next-cycle implication
`define RRTS_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rrts checker: property failed");

`endif

FILE: rtl/core/rrts_pkg.sv
// ----------------------------------------------------------------------------
// Round-robin thread scheduler package
// Widths, command and status codes, and the per-thread record.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rrts_pkg;

    localparam int THREADS  = 64;
    localparam int TID_W    = $clog2(THREADS);
    localparam int RUN_W    = TID_W + 1;
    localparam int CMD_W    = 3;
    localparam int STATUS_W = 3;
    localparam int ADDR_W   = 48;
    localparam int QUANTA_W = 16;
    localparam int SLEEP_W  = QUANTA_W + 1;
    localparam int COUNT_W  = 32;

    typedef logic [TID_W-1:0]   tid_t;
    typedef logic [RUN_W-1:0]   run_t;
    typedef logic [THREADS-1:0] mask_t;

    localparam run_t NONE_ID = run_t'(THREADS);

    typedef enum logic [CMD_W-1:0] {
        CMD_TICK   = 3'd0,
        CMD_SPAWN  = 3'd1,
        CMD_TERM   = 3'd2,
        CMD_BLOCK  = 3'd3,
        CMD_RESUME = 3'd4,
        CMD_SLEEP  = 3'd5,
        CMD_QUERY  = 3'd6
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK         = 3'd0,
        ST_NO_THREAD  = 3'd1,
        ST_NULL_ENTRY = 3'd2,
        ST_FULL       = 3'd3,
        ST_MAIN_BLOCK = 3'd4,
        ST_MAIN_SLEEP = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        RS_READY   = 2'd0,
        RS_RUNNING = 2'd1,
        RS_BLOCKED = 2'd2
    } rs_t;

    typedef struct packed {
        rs_t                  state;
        logic                 hold;
        logic [SLEEP_W-1:0]   sleep;
        logic [COUNT_W-1:0]   count;
        logic [ADDR_W-1:0]    start;
    } rec_t;

endpackage

FILE: rtl/core/rrts_if.sv
// ----------------------------------------------------------------------------
// Round-robin thread scheduler channels
// Command and result channels with valid/ready handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface rrts_cmd_if import rrts_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [CMD_W-1:0]    cmd;
    logic [TID_W-1:0]    thread_id;
    logic [ADDR_W-1:0]   entry_address;
    logic [QUANTA_W-1:0] sleep_quanta;

    modport source (output valid, cmd, thread_id, entry_address, sleep_quanta,
                    input ready);
    modport sink   (input valid, cmd, thread_id, entry_address, sleep_quanta,
                    output ready);
endinterface

interface rrts_res_if import rrts_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [TID_W-1:0]    spawned_id;
    logic [RUN_W-1:0]    running_now;
    logic                switched;
    logic [ADDR_W-1:0]   start_address;
    logic                first_run;
    logic [COUNT_W-1:0]  all_quanta;
    logic [COUNT_W-1:0]  thread_quanta;

    modport source (output valid, status, spawned_id, running_now, switched,
                    start_address, first_run, all_quanta, thread_quanta,
                    input ready);
    modport sink   (input valid, status, spawned_id, running_now, switched,
                    start_address, first_run, all_quanta, thread_quanta,
                    output ready);
endinterface

FILE: rtl/core/round_robin_thread_scheduler.sv
// ----------------------------------------------------------------------------
// Round-robin thread scheduler
// Thread records and the ready queue live in two synchronous memories;
// a sequencer reads, modifies and writes them back one entry at a time.
//
//   channel  dir  beat
//   req      in   cmd, thread_id, entry_address, sleep_quanta
//   rsp      out  status, spawned_id, running_now, switched, start_address,
//                 first_run, all_quanta, thread_quanta
//
// One command at a time: ready returns only once the result is loaded. A switch
// visits ids 1 to THREADS-1, reading the record of each used one, then pops the
// ready queue. Terminate and block of a queued thread walk the queue entries and
// close up the gap before any switch.
// Reset is immediate; no clearing pass. A held result does not stop the next
// command from being taken; it stalls only the delivery of the one after.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module round_robin_thread_scheduler
    import rrts_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    rrts_cmd_if.sink   req,
    rrts_res_if.source rsp
);

    typedef enum logic [13:0] {
        S_IDLE    = 14'b00000000000001,
        S_DECODE  = 14'b00000000000010,
        S_SPAWN   = 14'b00000000000100,
        S_RMW     = 14'b00000000001000,
        S_RM_RD   = 14'b00000000010000,
        S_RM_WR   = 14'b00000000100000,
        S_SW_CUR  = 14'b00000001000000,
        S_SW_PUSH = 14'b00000010000000,
        S_SWP_RD  = 14'b00000100000000,
        S_SWP_WR  = 14'b00001000000000,
        S_POP     = 14'b00010000000000,
        S_POP_ID  = 14'b00100000000000,
        S_DISP    = 14'b01000000000000,
        S_DONE    = 14'b10000000000000
    } fsm_t;

    localparam tid_t LAST_ID = tid_t'(THREADS - 1);

    // memories
    rec_t rec_mem [THREADS];
    tid_t ord_mem [THREADS];

    logic rec_re, rec_we, ord_re, ord_we;
    tid_t rec_raddr, rec_waddr, ord_raddr, ord_waddr, ord_wdata;
    rec_t rec_wdata;
    rec_t rec_q;
    tid_t ord_q;

    // control state
    fsm_t    state_reg, state_next;
    mask_t   used_reg, used_next;
    mask_t   written_reg, written_next;
    tid_t    head_reg, head_next;
    run_t    len_reg, len_next;
    run_t    cur_reg, cur_next;
    logic [COUNT_W-1:0] total_reg, total_next;
    logic    out_valid_reg, out_valid_next;
    logic    known_reg;
    tid_t    rd_addr_reg;

    // working registers
    cmd_t    cmd_reg, cmd_next;
    tid_t    tid_reg, tid_next;
    logic [ADDR_W-1:0]   entry_reg, entry_next;
    logic [QUANTA_W-1:0] quanta_reg, quanta_next;
    tid_t    idx_reg, idx_next;
    run_t    k_reg, k_next;
    logic    found_reg, found_next;
    logic [ADDR_W-1:0]   cur_start_reg, cur_start_next;
    status_t status_reg, status_next;
    tid_t    new_id_reg, new_id_next;
    logic    sw_reg, sw_next;
    logic    first_reg, first_next;
    logic [COUNT_W-1:0]  tq_reg, tq_next;

    // result registers
    logic                load_out;
    status_t             o_status_reg;
    tid_t                o_new_reg;
    run_t                o_run_reg;
    logic                o_sw_reg;
    logic [ADDR_W-1:0]   o_start_reg;
    logic                o_first_reg;
    logic [COUNT_W-1:0]  o_all_reg;
    logic [COUNT_W-1:0]  o_tq_reg;

    logic push_en;
    tid_t push_id;
    rec_t rec_view, rec_mod;
    logic cur_valid;

    always_ff @(posedge clk)
    begin
        if (rec_we)
        begin
            rec_mem[rec_waddr] <= rec_wdata;
        end
        if (rec_re)
        begin
            rec_q <= rec_mem[rec_raddr];
        end
        if (ord_we)
        begin
            ord_mem[ord_waddr] <= ord_wdata;
        end
        if (ord_re)
        begin
            ord_q <= ord_mem[ord_raddr];
        end
    end

    // a record never written reads as its reset value
    always_comb
    begin
        if (known_reg)
        begin
            rec_view = rec_q;
        end
        else if (rd_addr_reg == '0)
        begin
            rec_view = '{state: RS_RUNNING, hold: 1'b0, sleep: '0,
                         count: COUNT_W'(1), start: '0};
        end
        else
        begin
            rec_view = '{state: RS_READY, hold: 1'b0, sleep: '0, count: '0, start: '0};
        end
    end

    assign cur_valid = (cur_reg < NONE_ID) && used_reg[cur_reg[TID_W-1:0]];

    always_comb
    begin
        state_next     = state_reg;
        used_next      = used_reg;
        written_next   = written_reg;
        head_next      = head_reg;
        len_next       = len_reg;
        cur_next       = cur_reg;
        total_next     = total_reg;
        cmd_next       = cmd_reg;
        tid_next       = tid_reg;
        entry_next     = entry_reg;
        quanta_next    = quanta_reg;
        idx_next       = idx_reg;
        k_next         = k_reg;
        found_next     = found_reg;
        cur_start_next = cur_start_reg;
        status_next    = status_reg;
        new_id_next    = new_id_reg;
        sw_next        = sw_reg;
        first_next     = first_reg;
        tq_next        = tq_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        load_out       = 1'b0;
        rec_re         = 1'b0;
        rec_raddr      = idx_reg;
        rec_we         = 1'b0;
        rec_waddr      = rd_addr_reg;
        rec_mod        = rec_view;
        ord_re         = 1'b0;
        ord_raddr      = head_reg;
        ord_we         = 1'b0;
        ord_waddr      = head_reg;
        ord_wdata      = ord_q;
        push_en        = 1'b0;
        push_id        = idx_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    cmd_next    = cmd_t'(req.cmd);
                    tid_next    = req.thread_id;
                    entry_next  = req.entry_address;
                    quanta_next = req.sleep_quanta;
                    status_next = ST_OK;
                    new_id_next = '0;
                    sw_next     = 1'b0;
                    first_next  = 1'b0;
                    tq_next     = '0;
                    state_next  = S_DECODE;
                end
            end
            S_DECODE:
            begin
                case (cmd_reg)
                    CMD_TICK:
                    begin
                        state_next = S_SW_CUR;
                    end
                    CMD_SPAWN:
                    begin
                        if (entry_reg == '0)
                        begin
                            status_next = ST_NULL_ENTRY;
                            state_next  = S_DONE;
                        end
                        else
                        begin
                            idx_next   = tid_t'(1);
                            state_next = S_SPAWN;
                        end
                    end
                    CMD_TERM:
                    begin
                        if (!used_reg[tid_reg])
                        begin
                            status_next = ST_NO_THREAD;
                            state_next  = S_DONE;
                        end
                        else if (tid_reg == '0)
                        begin
                            state_next = S_DONE;
                        end
                        else
                        begin
                            used_next[tid_reg] = 1'b0;
                            k_next     = '0;
                            found_next = 1'b0;
                            state_next = S_RM_RD;
                        end
                    end
                    CMD_BLOCK, CMD_RESUME, CMD_QUERY:
                    begin
                        if (!used_reg[tid_reg])
                        begin
                            status_next = ST_NO_THREAD;
                            state_next  = S_DONE;
                        end
                        else if (cmd_reg == CMD_BLOCK && tid_reg == '0)
                        begin
                            status_next = ST_MAIN_BLOCK;
                            state_next  = S_DONE;
                        end
                        else
                        begin
                            rec_re     = 1'b1;
                            rec_raddr  = tid_reg;
                            state_next = S_RMW;
                        end
                    end
                    CMD_SLEEP:
                    begin
                        if (!cur_valid)
                        begin
                            status_next = ST_NO_THREAD;
                            state_next  = S_DONE;
                        end
                        else if (cur_reg == '0)
                        begin
                            status_next = ST_MAIN_SLEEP;
                            state_next  = S_DONE;
                        end
                        else
                        begin
                            rec_re     = 1'b1;
                            rec_raddr  = cur_reg[TID_W-1:0];
                            state_next = S_RMW;
                        end
                    end
                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end
            S_SPAWN:
            begin
                if (!used_reg[idx_reg])
                begin
                    used_next[idx_reg] = 1'b1;
                    rec_we      = 1'b1;
                    rec_waddr   = idx_reg;
                    rec_mod     = '{state: RS_READY, hold: 1'b0, sleep: '0,
                                    count: '0, start: entry_reg};
                    push_en     = 1'b1;
                    push_id     = idx_reg;
                    new_id_next = idx_reg;
                    state_next  = S_DONE;
                end
                else if (idx_reg == LAST_ID)
                begin
                    status_next = ST_FULL;
                    state_next  = S_DONE;
                end
                else
                begin
                    idx_next = idx_reg + tid_t'(1);
                end
            end
            S_RMW:
            begin
                case (cmd_reg)
                    CMD_BLOCK:
                    begin
                        rec_we       = 1'b1;
                        rec_mod.hold = 1'b1;
                        if (rec_view.state != RS_BLOCKED)
                        begin
                            rec_mod.state = RS_BLOCKED;
                            if ({1'b0, tid_reg} == cur_reg)
                            begin
                                state_next = S_SW_CUR;
                            end
                            else
                            begin
                                k_next     = '0;
                                found_next = 1'b0;
                                state_next = S_RM_RD;
                            end
                        end
                        else
                        begin
                            state_next = S_DONE;
                        end
                    end
                    CMD_RESUME:
                    begin
                        rec_we       = 1'b1;
                        rec_mod.hold = 1'b0;
                        if (rec_view.state == RS_BLOCKED && rec_view.sleep == '0)
                        begin
                            rec_mod.state = RS_READY;
                            push_en       = 1'b1;
                            push_id       = rd_addr_reg;
                        end
                        state_next = S_DONE;
                    end
                    CMD_SLEEP:
                    begin
                        rec_we        = 1'b1;
                        rec_mod.sleep = SLEEP_W'(quanta_reg) + SLEEP_W'(1);
                        rec_mod.state = RS_BLOCKED;
                        state_next    = S_SW_CUR;
                    end
                    default:
                    begin
                        tq_next    = rec_view.count;
                        state_next = S_DONE;
                    end
                endcase
            end
            S_RM_RD:
            begin
                if (k_reg == len_reg)
                begin
                    if (found_reg)
                    begin
                        len_next = len_reg - run_t'(1);
                    end
                    if (cmd_reg == CMD_TERM && {1'b0, tid_reg} == cur_reg)
                    begin
                        state_next = S_SW_CUR;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
                else
                begin
                    ord_re     = 1'b1;
                    ord_raddr  = head_reg + k_reg[TID_W-1:0];
                    state_next = S_RM_WR;
                end
            end
            S_RM_WR:
            begin
                if (found_reg)
                begin
                    ord_we    = 1'b1;
                    ord_waddr = head_reg + k_reg[TID_W-1:0] - tid_t'(1);
                    ord_wdata = ord_q;
                end
                if (ord_q == tid_reg)
                begin
                    found_next = 1'b1;
                end
                k_next     = k_reg + run_t'(1);
                state_next = S_RM_RD;
            end
            S_SW_CUR:
            begin
                if (cur_valid)
                begin
                    rec_re     = 1'b1;
                    rec_raddr  = cur_reg[TID_W-1:0];
                    state_next = S_SW_PUSH;
                end
                else
                begin
                    idx_next   = tid_t'(1);
                    state_next = S_SWP_RD;
                end
            end
            S_SW_PUSH:
            begin
                if (rec_view.state == RS_RUNNING)
                begin
                    rec_we        = 1'b1;
                    rec_mod.state = RS_READY;
                    push_en       = 1'b1;
                    push_id       = rd_addr_reg;
                end
                idx_next   = tid_t'(1);
                state_next = S_SWP_RD;
            end
            S_SWP_RD:
            begin
                if (used_reg[idx_reg])
                begin
                    rec_re     = 1'b1;
                    rec_raddr  = idx_reg;
                    state_next = S_SWP_WR;
                end
                else if (idx_reg == LAST_ID)
                begin
                    state_next = S_POP;
                end
                else
                begin
                    idx_next = idx_reg + tid_t'(1);
                end
            end
            S_SWP_WR:
            begin
                if (rec_view.sleep != '0)
                begin
                    rec_we        = 1'b1;
                    rec_mod.sleep = rec_view.sleep - SLEEP_W'(1);
                    if (rec_view.sleep == SLEEP_W'(1) && !rec_view.hold)
                    begin
                        rec_mod.state = RS_READY;
                        push_en       = 1'b1;
                        push_id       = rd_addr_reg;
                    end
                end
                if (idx_reg == LAST_ID)
                begin
                    state_next = S_POP;
                end
                else
                begin
                    idx_next   = idx_reg + tid_t'(1);
                    state_next = S_SWP_RD;
                end
            end
            S_POP:
            begin
                if (len_reg == '0)
                begin
                    cur_next   = NONE_ID;
                    state_next = S_DONE;
                end
                else
                begin
                    ord_re     = 1'b1;
                    ord_raddr  = head_reg;
                    head_next  = head_reg + tid_t'(1);
                    len_next   = len_reg - run_t'(1);
                    state_next = S_POP_ID;
                end
            end
            S_POP_ID:
            begin
                rec_re     = 1'b1;
                rec_raddr  = ord_q;
                state_next = S_DISP;
            end
            S_DISP:
            begin
                rec_we        = 1'b1;
                rec_mod.state = RS_RUNNING;
                if (rec_view.count != '1)
                begin
                    rec_mod.count = rec_view.count + COUNT_W'(1);
                end
                if (total_reg != '1)
                begin
                    total_next = total_reg + COUNT_W'(1);
                end
                first_next     = (rec_view.count == '0);
                cur_next       = {1'b0, rd_addr_reg};
                cur_start_next = rec_view.start;
                sw_next        = 1'b1;
                state_next     = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    load_out       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        rec_wdata = rec_mod;
        if (rec_we)
        begin
            written_next[rec_waddr] = 1'b1;
        end
        if (push_en && len_reg < NONE_ID)
        begin
            ord_we    = 1'b1;
            ord_waddr = head_reg + len_reg[TID_W-1:0];
            ord_wdata = push_id;
            len_next  = len_reg + run_t'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            used_reg      <= mask_t'(1);
            written_reg   <= '0;
            head_reg      <= '0;
            len_reg       <= '0;
            cur_reg       <= '0;
            total_reg     <= COUNT_W'(1);
            out_valid_reg <= 1'b0;
            known_reg     <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            used_reg      <= used_next;
            written_reg   <= written_next;
            head_reg      <= head_next;
            len_reg       <= len_next;
            cur_reg       <= cur_next;
            total_reg     <= total_next;
            out_valid_reg <= out_valid_next;
            if (rec_re)
            begin
                known_reg <= written_reg[rec_raddr];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg       <= cmd_next;
        tid_reg       <= tid_next;
        entry_reg     <= entry_next;
        quanta_reg    <= quanta_next;
        idx_reg       <= idx_next;
        k_reg         <= k_next;
        found_reg     <= found_next;
        cur_start_reg <= cur_start_next;
        status_reg    <= status_next;
        new_id_reg    <= new_id_next;
        sw_reg        <= sw_next;
        first_reg     <= first_next;
        tq_reg        <= tq_next;
        if (rec_re)
        begin
            rd_addr_reg <= rec_raddr;
        end
        if (load_out)
        begin
            o_status_reg <= status_reg;
            o_new_reg    <= new_id_reg;
            o_run_reg    <= cur_reg;
            o_sw_reg     <= sw_reg;
            o_start_reg  <= (cur_valid && cur_reg != '0) ? cur_start_reg : '0;
            o_first_reg  <= sw_reg && first_reg;
            o_all_reg    <= total_reg;
            o_tq_reg     <= tq_reg;
        end
    end

    assign req.ready         = (state_reg == S_IDLE);
    assign rsp.valid         = out_valid_reg;
    assign rsp.status        = o_status_reg;
    assign rsp.spawned_id    = o_new_reg;
    assign rsp.running_now   = o_run_reg;
    assign rsp.switched      = o_sw_reg;
    assign rsp.start_address = o_start_reg;
    assign rsp.first_run     = o_first_reg;
    assign rsp.all_quanta    = o_all_reg;
    assign rsp.thread_quanta = o_tq_reg;

endmodule

FILE: rtl/core/rrts_checker.sv
// ----------------------------------------------------------------------------
// Round-robin thread scheduler checker
// Port-level properties of the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "round_robin_thread_scheduler_defines.svh"

module rrts_checker
    import rrts_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    rrts_cmd_if.sink   req,
    rrts_res_if.source rsp
);

    `RRTS_ASSERT_NXT(a_rsp_hold, rsp.valid && !rsp.ready && !req.valid, rsp.valid)
    `RRTS_ASSERT_IMP(a_sw_has_thread, rsp.valid && rsp.switched, rsp.running_now != NONE_ID)
    `RRTS_ASSERT_IMP(a_none_quiet, rsp.valid && rsp.running_now == NONE_ID, !rsp.switched)
    `RRTS_ASSERT_IMP(a_first_on_sw, rsp.valid && rsp.first_run, rsp.switched)
    `RRTS_ASSERT_IMP(a_err_no_effect, rsp.valid && rsp.status != ST_OK, rsp.spawned_id == '0)

endmodule

bind round_robin_thread_scheduler rrts_checker u_rrts_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .rsp   (rsp)
);

FILE: dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Round-robin thread scheduler testbench
// Sends scheduler commands over the request channel and compares every
// response beat against an in-bench scheduler model. A short table covers
// the error codes other than ST_FULL and edge values; a weighted random run follows, with
// random stalls on both channels, a long response hold-off and a drain pause.
// ----------------------------------------------------------------------------

module tb;
    import rrts_pkg::*;

    localparam int N_RANDOM   = 1650;
    localparam int IDLE_PCT   = 32;
    localparam int QUIET_LO   = 300;
    localparam int QUIET_HI   = 520;
    localparam int HOLD_AT    = 700;
    localparam int HOLD_LEN   = 400;
    localparam int PAUSE_AT   = 1200;
    localparam int FILL_LO    = 900;
    localparam int FILL_HI    = 1050;
    localparam int STUCK_MAX  = 20000;
    localparam logic [31:0] SAT = '1;

    typedef struct {
        cmd_t                cmd;
        tid_t                tid;
        logic [ADDR_W-1:0]   entry;
        logic [QUANTA_W-1:0] quanta;
        logic                pinned;
        status_t             status;
    } row_t;

    typedef struct {
        status_t            status;
        tid_t               spawned_id;
        run_t               running_now;
        logic               switched;
        logic [ADDR_W-1:0]  start_address;
        logic               first_run;
        logic [COUNT_W-1:0] all_quanta;
        logic [COUNT_W-1:0] thread_quanta;
    } beat_t;

    logic clk;
    logic rst_n;

    rrts_cmd_if req ();
    rrts_res_if rsp ();

    round_robin_thread_scheduler dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req.sink),
        .rsp   (rsp.source)
    );

    logic               used   [THREADS];
    rs_t                rstate [THREADS];
    logic               held   [THREADS];
    logic [SLEEP_W-1:0] naps   [THREADS];
    logic [COUNT_W-1:0] runs   [THREADS];
    logic [ADDR_W-1:0]  entries[THREADS];
    tid_t               ready_q[$];
    run_t               cur;
    logic [COUNT_W-1:0] total;

    beat_t   pending[$];
    int      errors;
    int      sent;
    int      stuck;
    logic    hold_rsp;
    logic    pin_now;
    status_t pin_status;
    row_t    table_rows[$];

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic logic live(run_t id);
        return id < THREADS && used[id[TID_W-1:0]];
    endfunction

    function automatic void enqueue(tid_t id);
        if (ready_q.size() < THREADS)
            ready_q.insert(ready_q.size(), id);
    endfunction

    function automatic void dequeue(tid_t id);
        foreach (ready_q[i])
        begin
            if (ready_q[i] == id)
            begin
                ready_q.delete(i);
                return;
            end
        end
    endfunction

    function automatic logic reschedule(output logic first);
        tid_t nxt;
        first = 1'b0;
        if (live(cur) && rstate[cur[TID_W-1:0]] == RS_RUNNING)
        begin
            rstate[cur[TID_W-1:0]] = RS_READY;
            enqueue(cur[TID_W-1:0]);
        end
        for (int i = 1; i < THREADS; i++)
        begin
            if (used[i] && naps[i] != 0)
            begin
                naps[i]--;
                if (naps[i] == 0 && !held[i])
                begin
                    rstate[i] = RS_READY;
                    enqueue(tid_t'(i));
                end
            end
        end
        if (ready_q.size() == 0)
        begin
            cur = NONE_ID;
            return 1'b0;
        end
        nxt = ready_q[0];
        ready_q.delete(0);
        cur = run_t'(nxt);
        rstate[nxt] = RS_RUNNING;
        if (total != SAT) total++;
        first = (runs[nxt] == 0);
        if (runs[nxt] != SAT) runs[nxt]++;
        return 1'b1;
    endfunction

    function automatic void sched_reset();
        for (int i = 0; i < THREADS; i++)
        begin
            used[i]    = 1'b0;
            rstate[i]  = RS_READY;
            held[i]    = 1'b0;
            naps[i]    = '0;
            runs[i]    = '0;
            entries[i] = '0;
        end
        used[0]   = 1'b1;
        rstate[0] = RS_RUNNING;
        runs[0]   = 1;
        ready_q.delete();
        cur   = '0;
        total = 1;
    endfunction

    function automatic beat_t schedule(logic [CMD_W-1:0] op, tid_t tid,
                                       logic [ADDR_W-1:0] entry,
                                       logic [QUANTA_W-1:0] quanta);
        beat_t r;
        logic  first;
        int    slot;
        r = '{status: ST_OK, spawned_id: '0, running_now: '0, switched: 1'b0,
              start_address: '0, first_run: 1'b0, all_quanta: '0,
              thread_quanta: '0};
        first = 1'b0;
        case (op)
            CMD_TICK:
                r.switched = reschedule(first);
            CMD_SPAWN:
            begin
                slot = THREADS;
                for (int i = THREADS - 1; i >= 1; i--)
                    if (!used[i]) slot = i;
                if (entry == 0)
                    r.status = ST_NULL_ENTRY;
                else if (slot == THREADS)
                    r.status = ST_FULL;
                else
                begin
                    used[slot]    = 1'b1;
                    rstate[slot]  = RS_READY;
                    held[slot]    = 1'b0;
                    naps[slot]    = '0;
                    runs[slot]    = '0;
                    entries[slot] = entry;
                    enqueue(tid_t'(slot));
                    r.spawned_id = tid_t'(slot);
                end
            end
            CMD_TERM:
            begin
                if (!live(run_t'(tid)))
                    r.status = ST_NO_THREAD;
                else if (tid != 0)
                begin
                    dequeue(tid);
                    used[tid]   = 1'b0;
                    rstate[tid] = RS_READY;
                    held[tid]   = 1'b0;
                    naps[tid]   = '0;
                    if (run_t'(tid) == cur)
                        r.switched = reschedule(first);
                end
            end
            CMD_BLOCK:
            begin
                if (!live(run_t'(tid)))
                    r.status = ST_NO_THREAD;
                else if (tid == 0)
                    r.status = ST_MAIN_BLOCK;
                else
                begin
                    held[tid] = 1'b1;
                    if (rstate[tid] != RS_BLOCKED)
                    begin
                        rstate[tid] = RS_BLOCKED;
                        if (run_t'(tid) == cur)
                            r.switched = reschedule(first);
                        else
                            dequeue(tid);
                    end
                end
            end
            CMD_RESUME:
            begin
                if (!live(run_t'(tid)))
                    r.status = ST_NO_THREAD;
                else
                begin
                    held[tid] = 1'b0;
                    if (rstate[tid] == RS_BLOCKED && naps[tid] == 0)
                    begin
                        rstate[tid] = RS_READY;
                        enqueue(tid);
                    end
                end
            end
            CMD_SLEEP:
            begin
                if (!live(cur))
                    r.status = ST_NO_THREAD;
                else if (cur == 0)
                    r.status = ST_MAIN_SLEEP;
                else
                begin
                    naps[cur[TID_W-1:0]]   = SLEEP_W'(quanta) + 1'b1;
                    rstate[cur[TID_W-1:0]] = RS_BLOCKED;
                    r.switched = reschedule(first);
                end
            end
            CMD_QUERY:
            begin
                if (!live(run_t'(tid)))
                    r.status = ST_NO_THREAD;
                else
                    r.thread_quanta = runs[tid];
            end
            default: ;
        endcase
        r.running_now   = cur;
        r.start_address = (cur != 0 && live(cur)) ? entries[cur[TID_W-1:0]] : '0;
        r.first_run     = r.switched & first;
        r.all_quanta    = total;
        return r;
    endfunction

    function automatic row_t mk(cmd_t c, int t, logic [ADDR_W-1:0] e,
                                logic [QUANTA_W-1:0] q, logic p, status_t s);
        row_t r;
        r = '{cmd: c, tid: tid_t'(t), entry: e, quanta: q, pinned: p, status: s};
        return r;
    endfunction

    function automatic void add_row(row_t r);
        table_rows.insert(table_rows.size(), r);
    endfunction

    function automatic tid_t pick_tid();
        int t;
        if ($urandom_range(99) < 80)
        begin
            for (int k = 0; k < 8; k++)
            begin
                t = $urandom_range(THREADS - 1);
                if (used[t]) return tid_t'(t);
            end
        end
        return tid_t'($urandom_range(THREADS - 1));
    endfunction

    function automatic row_t random_row(int n);
        row_t r;
        int   w;
        w = $urandom_range(99);
        r.pinned = 1'b0;
        r.status = ST_OK;
        if (n >= FILL_LO && n < FILL_HI)
            r.cmd = (w < 60) ? CMD_SPAWN : (w < 80) ? CMD_TICK : CMD_QUERY;
        else if (w < 30) r.cmd = CMD_TICK;
        else if (w < 44) r.cmd = CMD_SPAWN;
        else if (w < 55) r.cmd = CMD_TERM;
        else if (w < 65) r.cmd = CMD_BLOCK;
        else if (w < 77) r.cmd = CMD_RESUME;
        else if (w < 88) r.cmd = CMD_SLEEP;
        else if (w < 97) r.cmd = CMD_QUERY;
        else             r.cmd = cmd_t'(3'd7);
        r.tid    = pick_tid();
        r.entry  = ADDR_W'({$urandom(), $urandom()});
        if ($urandom_range(19) == 0) r.entry = '0;
        r.quanta = ($urandom_range(99) < 90) ? QUANTA_W'($urandom_range(3))
                                            : QUANTA_W'($urandom());
        return r;
    endfunction

    task automatic drive(row_t r, int n);
        @(negedge clk);
        if (n < QUIET_LO || n >= QUIET_HI)
        begin
            while ($urandom_range(99) < IDLE_PCT)
            begin
                req.valid <= 1'b0;
                @(negedge clk);
            end
        end
        req.valid         <= 1'b1;
        req.cmd           <= r.cmd;
        req.thread_id     <= r.tid;
        req.entry_address <= r.entry;
        req.sleep_quanta  <= r.quanta;
        pin_now           <= r.pinned;
        pin_status        <= r.status;
        do
            @(posedge clk);
        while (!req.ready);
        sent++;
    endtask

    always @(posedge clk)
    begin
        beat_t e;
        if (rst_n && req.valid && req.ready)
        begin
            e = schedule(req.cmd, req.thread_id, req.entry_address, req.sleep_quanta);
            if (pin_now) e.status = pin_status;
            pending.insert(pending.size(), e);
        end
        if (rst_n && rsp.valid && rsp.ready)
        begin
            if (pending.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected response beat, status %0d", $time, rsp.status);
            end
            else
            begin
                e = pending[0];
                pending.delete(0);
                if (rsp.status !== e.status || rsp.spawned_id !== e.spawned_id ||
                    rsp.running_now !== e.running_now || rsp.switched !== e.switched ||
                    rsp.start_address !== e.start_address ||
                    rsp.first_run !== e.first_run || rsp.all_quanta !== e.all_quanta ||
                    rsp.thread_quanta !== e.thread_quanta)
                begin
                    errors++;
                    $display("%0t: expected st=%0d id=%0d run=%0d sw=%0b a=%h fr=%0b all=%0d tq=%0d",
                             $time, e.status, e.spawned_id, e.running_now, e.switched,
                             e.start_address, e.first_run, e.all_quanta, e.thread_quanta);
                    $display("%0t: actual   st=%0d id=%0d run=%0d sw=%0b a=%h fr=%0b all=%0d tq=%0d",
                             $time, rsp.status, rsp.spawned_id, rsp.running_now,
                             rsp.switched, rsp.start_address, rsp.first_run,
                             rsp.all_quanta, rsp.thread_quanta);
                end
            end
        end
    end

    always @(negedge clk)
    begin
        if (hold_rsp || (!(sent >= QUIET_LO && sent < QUIET_HI) &&
                         $urandom_range(99) < IDLE_PCT))
            rsp.ready <= 1'b0;
        else
            rsp.ready <= 1'b1;
    end

    initial
    begin
        hold_rsp = 1'b0;
        wait (sent >= HOLD_AT);
        @(negedge clk);
        hold_rsp = 1'b1;
        repeat (HOLD_LEN) @(negedge clk);
        hold_rsp = 1'b0;
    end

    always @(posedge clk)
    begin
        if (!rst_n || (req.valid && req.ready) || (rsp.valid && rsp.ready))
            stuck <= 0;
        else
            stuck <= stuck + 1;
        if (stuck >= STUCK_MAX)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial
    begin
        int guard;
        errors = 0;
        sent   = 0;
        stuck  = 0;
        rst_n  = 1'b0;
        req.valid         = 1'b0;
        req.cmd           = CMD_TICK;
        req.thread_id     = '0;
        req.entry_address = '0;
        req.sleep_quanta  = '0;
        rsp.ready         = 1'b0;
        pin_now           = 1'b0;
        pin_status        = ST_OK;
        sched_reset();

        add_row(mk(CMD_QUERY,  0, '0, '0, 1'b1, ST_OK));
        add_row(mk(CMD_SLEEP,  0, '0, '0, 1'b1, ST_MAIN_SLEEP));
        add_row(mk(CMD_BLOCK,  0, '0, '0, 1'b1, ST_MAIN_BLOCK));
        add_row(mk(CMD_TERM,   0, '0, '0, 1'b1, ST_OK));
        add_row(mk(CMD_TERM,  63, '0, '0, 1'b1, ST_NO_THREAD));
        add_row(mk(CMD_QUERY, 63, '0, '0, 1'b1, ST_NO_THREAD));
        add_row(mk(CMD_RESUME, 5, '0, '0, 1'b1, ST_NO_THREAD));
        add_row(mk(CMD_SPAWN,  0, '0, '0, 1'b1, ST_NULL_ENTRY));
        add_row(mk(CMD_SPAWN, 63, '1, '0, 1'b1, ST_OK));
        add_row(mk(CMD_SPAWN,  0, 48'h1, '0, 1'b1, ST_OK));
        add_row(mk(CMD_SPAWN,  0, 48'h8000_0000_0000, '0, 1'b1, ST_OK));
        add_row(mk(CMD_TICK,   0, '0, '0, 1'b0, ST_OK));
        add_row(mk(CMD_SLEEP,  0, '0, '0, 1'b0, ST_OK));
        add_row(mk(CMD_TICK,   0, '0, '0, 1'b0, ST_OK));
        add_row(mk(CMD_BLOCK,  2, '0, '0, 1'b0, ST_OK));
        add_row(mk(CMD_BLOCK,  2, '0, '0, 1'b0, ST_OK));
        add_row(mk(CMD_TICK,   0, '0, '0, 1'b0, ST_OK));
        add_row(mk(CMD_RESUME, 2, '0, '0, 1'b0, ST_OK));
        add_row(mk(CMD_SLEEP,  0, '0, 16'hFFFF, 1'b0, ST_OK));
        add_row(mk(CMD_TICK,   0, '0, '0, 1'b0, ST_OK));
        add_row(mk(CMD_TERM,   3, '0, '0, 1'b0, ST_OK));
        add_row(mk(CMD_QUERY,  2, '0, '0, 1'b0, ST_OK));
        add_row(mk(cmd_t'(3'd7), 0, '0, '0, 1'b1, ST_OK));

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (table_rows[i])
            drive(table_rows[i], sent);
        for (int n = 0; n < N_RANDOM; n++)
        begin
            if (n == PAUSE_AT)
            begin
                @(negedge clk);
                req.valid <= 1'b0;
                wait (pending.size() == 0);
            end
            drive(random_row(n), sent);
        end
        @(negedge clk);
        req.valid <= 1'b0;

        guard = 0;
        while (pending.size() != 0 && guard < STUCK_MAX)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (200) @(posedge clk);
        if (errors == 0 && pending.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
